// ===== rtl/idpr_pkg.sv =====
// Shared types and constants for the int8 dot product / requantize block.
// No dependencies; compile first.
package idpr_pkg;

    localparam int BYTE_W          = 8;
    localparam int BYTES_PER_FIELD = 4;
    localparam int FIELD_W         = BYTE_W * BYTES_PER_FIELD;
    localparam int ACC_W           = 32;
    localparam int SCALE_W         = 32;
    localparam int PROD_W          = ACC_W + SCALE_W;
    localparam int LANE_PROD_W     = 2 * BYTE_W;
    localparam int ZP_W            = 8;
    localparam int CLIP_BITS       = 7;
    localparam int CLIP_HI         = (1 << CLIP_BITS) - 1;
    localparam int CLIP_LO         = -(1 << CLIP_BITS);
    // Magnitudes at or above 2^SAT_BITS clip for any zero point.
    localparam int SAT_BITS        = CLIP_BITS + 1;

    typedef logic [ACC_W-1:0] acc_t;

    // Request handed from the accumulator to the requantizer.
    typedef struct packed {
        logic [ACC_W-1:0]   sum;
        logic [SCALE_W-1:0] scale;
        logic               requantize;
    } rq_req_t;

endpackage

// ===== rtl/idpr_if.sv =====
// Channel interfaces: input beat, result beat and zero point write.
// No dependencies.
interface idpr_in_if;
    logic               valid;
    logic               ready;
    logic [31:0]        activations;
    logic [31:0]        weights_group;
    logic               first;
    logic signed [31:0] start_sum;
    logic               last;
    logic               requantize;
    logic [31:0]        scale;

    modport source (output valid, activations, weights_group, first, start_sum, last,
                    requantize, scale, input ready);
    modport sink   (input valid, activations, weights_group, first, start_sum, last,
                    requantize, scale, output ready);
endinterface

interface idpr_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] result;

    modport source (output valid, result, input ready);
    modport sink   (input valid, result, output ready);
endinterface

interface idpr_cfg_if;
    logic              valid;
    logic              ready;
    logic signed [7:0] output_zero_point;

    modport source (output valid, output_zero_point, input ready);
    modport sink   (input valid, output_zero_point, output ready);
endinterface

// ===== rtl/int8_dot_product_requantize.sv =====
// Top level of the int8 dot product with requantization.
// Depends on idpr_pkg, idpr_if, idpr_lane and idpr_requant.
//
// Each input beat carries LANES signed byte activation/weight pairs; the lanes
// multiply them side by side and a merge adder folds the products into the
// 32-bit wrapping accumulator in the same cycle, so one beat is taken every
// clock unless din.ready is low. A beat with first set seeds the sum from
// start_sum. A beat with last set sends the sum down a four-register requantize
// pipeline (request capture, magnitude, 32x32 scale multiply, round/offset/clip
// into the output register; with requantize clear the raw sum passes), and
// dout.valid rises once it reaches the output register. While a result waits
// on dout the whole pipeline holds and din.ready drops. The zero point register
// is written on the cfg channel, which is always ready; write it only while idle.
module int8_dot_product_requantize
    import idpr_pkg::*;
#(
    parameter int LANES           = 4,
    parameter int SCALE_FRAC_BITS = 24
)
(
    input  logic       clk,
    input  logic       rst_n,
    idpr_in_if.sink    din,
    idpr_out_if.source dout,
    idpr_cfg_if.sink   cfg
);

    logic signed [LANE_PROD_W-1:0] prod [LANES];
    acc_t                          acc_reg, acc_next;
    acc_t                          lane_sum;
    logic signed [ZP_W-1:0]        zp_reg;
    logic                          adv;
    logic                          in_fire;
    rq_req_t                       req;

    // Lanes past the 32-bit fields see zero bytes, so they add nothing.
    for (genvar gl = 0; gl < LANES; gl++)
    begin : g_lane
        if (gl < BYTES_PER_FIELD)
        begin : g_mul
            idpr_lane u_lane (
                .act  ($signed(din.activations[gl*BYTE_W +: BYTE_W])),
                .wgt  ($signed(din.weights_group[gl*BYTE_W +: BYTE_W])),
                .prod (prod[gl])
            );
        end
        else
        begin : g_zero
            assign prod[gl] = '0;
        end
    end

    // Merge: sign-extend each lane product and add with wrap.
    always_comb
    begin
        lane_sum = '0;
        for (int l = 0; l < LANES; l++)
            lane_sum = lane_sum + ACC_W'(prod[l]);
        acc_next = (din.first ? acc_t'(din.start_sum) : acc_reg) + lane_sum;
    end

    assign din.ready = adv;
    assign in_fire   = din.valid && din.ready;

    // Hand the finished sum to the requantizer on a last beat.
    assign req.sum        = acc_next;
    assign req.scale      = din.scale;
    assign req.requantize = din.requantize;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
            zp_reg  <= '0;
        end
        else
        begin
            if (in_fire)
                acc_reg <= acc_next;
            if (cfg.valid)
                zp_reg <= cfg.output_zero_point;
        end
    end

    assign cfg.ready = 1'b1;

    idpr_requant #(
        .SCALE_FRAC_BITS (SCALE_FRAC_BITS)
    ) u_requant (
        .clk        (clk),
        .rst_n      (rst_n),
        .zero_point (zp_reg),
        .req_valid  (in_fire && din.last),
        .req        (req),
        .adv        (adv),
        .res_valid  (dout.valid),
        .res_ready  (dout.ready),
        .result     (dout.result)
    );

endmodule

// ===== rtl/idpr_lane.sv =====
// One multiply lane: signed byte times signed byte.
// Depends on idpr_pkg.
module idpr_lane
    import idpr_pkg::*;
(
    input  logic signed [BYTE_W-1:0]      act,
    input  logic signed [BYTE_W-1:0]      wgt,
    output logic signed [LANE_PROD_W-1:0] prod
);

    assign prod = act * wgt;

endmodule

// ===== rtl/idpr_requant.sv =====
// Requantize: capture, magnitude, 32x32 scale multiply, round/offset/clip, output register.
// Depends on idpr_pkg.
module idpr_requant
    import idpr_pkg::*;
#(
    parameter int SCALE_FRAC_BITS = 24
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic signed [ZP_W-1:0] zero_point,
    input  logic                   req_valid,
    input  rq_req_t                req,
    output logic                   adv,
    output logic                   res_valid,
    input  logic                   res_ready,
    output logic signed [ACC_W-1:0] result
);

    localparam int QS_W = SAT_BITS + 1;
    localparam int V_W  = SAT_BITS + 3;
    localparam logic signed [V_W-1:0] V_HI = V_W'(CLIP_HI);
    localparam logic signed [V_W-1:0] V_LO = V_W'(CLIP_LO);

    // stage 1: captured request
    logic                v1_reg, v1_next;
    rq_req_t             r1_reg, r1_next;
    // stage 2: sign and magnitude
    logic                v2_reg, v2_next;
    logic                neg2_reg, neg2_next;
    logic [ACC_W-1:0]    mag2_reg, mag2_next;
    logic [SCALE_W-1:0]  scale2_reg, scale2_next;
    logic                rq2_reg, rq2_next;
    logic [ACC_W-1:0]    raw2_reg, raw2_next;
    // stage 3: full product
    logic                v3_reg, v3_next;
    logic                neg3_reg, neg3_next;
    logic [PROD_W-1:0]   prod3_reg, prod3_next;
    logic                rq3_reg, rq3_next;
    logic [ACC_W-1:0]    raw3_reg, raw3_next;
    // output register
    logic                vo_reg, vo_next;
    logic [ACC_W-1:0]    res_reg, res_next;

    logic [PROD_W-1:0]       rnd, q;
    logic [QS_W-1:0]         qs;
    logic signed [V_W-1:0]   sq, v, vc;

    // Whole pipeline moves together; only a held result stops it.
    assign adv = !vo_reg || res_ready;

    always_comb
    begin
        v1_next     = req_valid;
        r1_next     = req;
        v2_next     = v1_reg;
        neg2_next   = r1_reg.sum[ACC_W-1];
        mag2_next   = r1_reg.sum[ACC_W-1] ? (~r1_reg.sum + ACC_W'(1)) : r1_reg.sum;
        scale2_next = r1_reg.scale;
        rq2_next    = r1_reg.requantize;
        raw2_next   = r1_reg.sum;
        v3_next     = v2_reg;
        neg3_next   = neg2_reg;
        prod3_next  = PROD_W'(mag2_reg) * PROD_W'(scale2_reg);
        rq3_next    = rq2_reg;
        raw3_next   = raw2_reg;
    end

    // Round half away from zero on the magnitude, restore sign, offset, clip.
    always_comb
    begin
        rnd = prod3_reg + (PROD_W'(1) << (SCALE_FRAC_BITS - 1));
        q   = rnd >> SCALE_FRAC_BITS;
        if (|q[PROD_W-1:SAT_BITS])
            qs = QS_W'(1) << SAT_BITS;
        else
            qs = QS_W'(q[SAT_BITS-1:0]);
        sq = neg3_reg ? -$signed(V_W'(qs)) : $signed(V_W'(qs));
        v  = sq + V_W'(zero_point);
        if (v > V_HI)
            vc = V_HI;
        else if (v < V_LO)
            vc = V_LO;
        else
            vc = v;
        vo_next  = v3_reg;
        res_next = rq3_reg ? ACC_W'(vc) : raw3_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
            vo_reg <= vo_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            r1_reg     <= r1_next;
            neg2_reg   <= neg2_next;
            mag2_reg   <= mag2_next;
            scale2_reg <= scale2_next;
            rq2_reg    <= rq2_next;
            raw2_reg   <= raw2_next;
            neg3_reg   <= neg3_next;
            prod3_reg  <= prod3_next;
            rq3_reg    <= rq3_next;
            raw3_reg   <= raw3_next;
            res_reg    <= res_next;
        end
    end

    assign res_valid = vo_reg;
    assign result    = $signed(res_reg);

endmodule

// ===== rtl/idpr_checker.sv =====
// Port-level checks for int8_dot_product_requantize, attached by bind.
// Depends on the top level's interface ports only.
module idpr_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        din_valid,
    input logic        din_ready,
    input logic        dout_valid,
    input logic        dout_ready,
    input logic [31:0] dout_result
);

    // Hold a stalled result beat.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        dout_valid && !dout_ready |=> dout_valid)
        else $error("result beat dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        dout_valid && !dout_ready |=> $stable(dout_result))
        else $error("result changed while stalled");

    // A stalled output must stop the input side.
    a_stall_in: assert property (@(posedge clk) disable iff (!rst_n)
        dout_valid && !dout_ready |-> !din_ready)
        else $error("input taken while output stalled");

    // Input only stalls because of a waiting result.
    a_ready_why: assert property (@(posedge clk) disable iff (!rst_n)
        !din_ready |-> dout_valid && !dout_ready)
        else $error("input stalled without output back pressure");

    // Take no input beat while a result is stalled.
    a_accept_ok: assert property (@(posedge clk) disable iff (!rst_n)
        din_valid && din_ready |-> !(dout_valid && !dout_ready))
        else $error("beat accepted during output stall");

endmodule

bind int8_dot_product_requantize idpr_checker u_idpr_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .din_valid   (din.valid),
    .din_ready   (din.ready),
    .dout_valid  (dout.valid),
    .dout_ready  (dout.ready),
    .dout_result (dout.result)
);
